@@ sv/grif_pkg.sv @@
// ---------------------------------------------------------------------------
// Griffin permutation package
// Field constants, element file layout, power-chain tables and shared types.
// ---------------------------------------------------------------------------
package grif_pkg;

    localparam int FE_W     = 256;
    localparam int FE_AW    = 6;
    localparam int FE_DEPTH = 64;
    localparam int LIMBS    = 4;

    localparam logic [FE_W-1:0] MODULUS =
        256'h73eda753299d7d483339d80809a1d80553bda402fffe5bfeffffffff00000001;

    // function codes of the input transaction
    localparam logic [1:0] FN_STATE  = 2'd0;
    localparam logic [1:0] FN_KEY    = 2'd1;
    localparam logic [1:0] FN_COEF   = 2'd2;
    localparam logic [1:0] FN_UNUSED = 2'd3;

    // element file layout; chain prefix products live at 0..21, 21 doubles as accumulator
    localparam logic [FE_AW-1:0] FA_ACC  = 6'd21;
    localparam logic [FE_AW-1:0] FA_S    = 6'd24;
    localparam logic [FE_AW-1:0] FA_X    = 6'd28;
    localparam logic [FE_AW-1:0] FA_C    = 6'd32;
    localparam logic [FE_AW-1:0] FA_SUM  = 6'd36;
    localparam logic [FE_AW-1:0] FA_T    = 6'd37;
    localparam logic [FE_AW-1:0] FA_RES  = 6'd38;
    localparam logic [FE_AW-1:0] FA_PREV = 6'd39;
    localparam logic [FE_AW-1:0] FA_K    = 6'd40;
    localparam logic [FE_AW-1:0] FA_ACC2 = 6'd41;

    // x^(1/5) addition chain
    localparam int PRE_LEN  = 22;
    localparam int TAIL_LEN = 36;
    localparam logic [4:0] CHAIN_PRE_A [PRE_LEN] = '{
        5'd22, 5'd0, 5'd22, 5'd0, 5'd2, 5'd22, 5'd0, 5'd0, 5'd0, 5'd0, 5'd1,
        5'd4, 5'd0, 5'd0, 5'd0, 5'd1, 5'd1, 5'd1, 5'd0, 5'd1, 5'd1, 5'd12};
    localparam logic [4:0] CHAIN_PRE_B [PRE_LEN] = '{
        5'd22, 5'd0, 5'd1, 5'd2, 5'd2, 5'd4, 5'd5, 5'd6, 5'd7, 5'd8, 5'd9,
        5'd10, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15, 5'd16, 5'd17, 5'd18, 5'd19, 5'd19};
    localparam logic [3:0] CHAIN_TAIL_SQ [TAIL_LEN] = '{
        4'd6, 4'd6, 4'd6, 4'd6, 4'd5, 4'd6, 4'd8, 4'd8, 4'd6, 4'd6, 4'd7, 4'd8,
        4'd6, 4'd8, 4'd6, 4'd6, 4'd3, 4'd15, 4'd5, 4'd7, 4'd1, 4'd10, 4'd6, 4'd5,
        4'd8, 4'd7, 4'd9, 4'd7, 4'd8, 4'd8, 4'd8, 4'd6, 4'd8, 4'd8, 4'd8, 4'd6};
    localparam logic [4:0] CHAIN_TAIL_M [TAIL_LEN] = '{
        5'd16, 5'd11, 5'd20, 5'd18, 5'd10, 5'd10, 5'd12, 5'd11, 5'd17, 5'd11,
        5'd13, 5'd15, 5'd6, 5'd17, 5'd15, 5'd14, 5'd3, 5'd8, 5'd22, 5'd20,
        5'd2, 5'd19, 5'd14, 5'd9, 5'd17, 5'd7, 5'd17, 5'd9, 5'd17, 5'd17,
        5'd17, 5'd5, 5'd17, 5'd17, 5'd17, 5'd6};

    typedef enum logic {
        FOP_ADD,
        FOP_MUL
    } fop_t;

    typedef struct packed {
        logic start;
        fop_t op;
    } alu_req_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [5:0]  element;
        logic [1:0]  limb;
        logic [63:0] word;
        logic        start_req;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  out_element;
        logic [1:0]  out_limb;
        logic [63:0] out_word;
        logic        last;
    } out_item_t;

    // chain index 22 is the input element itself, held in state slot 0
    function automatic logic [FE_AW-1:0] chain_addr(input logic [4:0] c);
        chain_addr = (c == 5'd22) ? FA_S : {1'b0, c};
    endfunction

endpackage

@@ sv/grif_falu.sv @@
// ---------------------------------------------------------------------------
// Griffin field unit
// Shared modular adder/reducer and bit-serial modular multiplier mod r.
// ---------------------------------------------------------------------------
module grif_falu import grif_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  alu_req_t        req,
    input  logic [FE_W-1:0] a,
    input  logic [FE_W-1:0] b,
    output logic            done,
    output logic [FE_W-1:0] y
);

    localparam int MUL_STEPS = FE_W - 1;

    typedef enum logic [1:0] {
        A_IDLE,
        A_RED,
        A_DBL,
        A_ADD
    } alu_state_t;

    alu_state_t      state_reg;
    logic            done_reg;
    logic [FE_W:0]   val_reg;
    logic [FE_W-1:0] a_reg;
    logic [FE_W-2:0] b_reg;
    logic [7:0]      cnt_reg;

    logic [FE_W:0]   t;
    logic [FE_W+1:0] diff;
    logic            ge;
    logic [FE_W:0]   red;

    always_comb begin
        case (state_reg)
            A_DBL:   t = {val_reg[FE_W-1:0], 1'b0};
            A_ADD:   t = val_reg + (b_reg[FE_W-2] ? {1'b0, a_reg} : '0);
            default: t = val_reg;
        endcase
        diff = {1'b0, t} - {2'b00, MODULUS};
        ge   = !diff[FE_W+1];
        red  = ge ? diff[FE_W:0] : t;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= A_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            case (state_reg)
                A_IDLE: begin
                    if (req.start) begin
                        if (req.op == FOP_ADD) begin
                            val_reg   <= {1'b0, a} + {1'b0, b};
                            state_reg <= A_RED;
                        end else begin
                            val_reg   <= '0;
                            a_reg     <= a;
                            b_reg     <= b[FE_W-2:0];
                            cnt_reg   <= '0;
                            state_reg <= A_DBL;
                        end
                    end
                end
                A_RED: begin
                    // subtract r until canonical
                    if (ge) begin
                        val_reg <= red;
                    end else begin
                        done_reg  <= 1'b1;
                        state_reg <= A_IDLE;
                    end
                end
                A_DBL: begin
                    val_reg   <= red;
                    state_reg <= A_ADD;
                end
                A_ADD: begin
                    val_reg <= red;
                    b_reg   <= {b_reg[FE_W-3:0], 1'b0};
                    if (cnt_reg == 8'(MUL_STEPS - 1)) begin
                        done_reg  <= 1'b1;
                        state_reg <= A_IDLE;
                    end else begin
                        cnt_reg   <= cnt_reg + 8'd1;
                        state_reg <= A_DBL;
                    end
                end
                default: state_reg <= A_IDLE;
            endcase
        end
    end

    assign done = done_reg;
    assign y    = val_reg[FE_W-1:0];

endmodule

@@ sv/griffin_permutation_unit.sv @@
// ---------------------------------------------------------------------------
// Griffin permutation unit
// Griffin permutation over the BLS12-381 scalar field, state width 3 or 4,
// run by a micro-sequencer over one shared modular add/multiply unit.
// ---------------------------------------------------------------------------
//  channel  | direction | handshake         | payload
//  s_       | in        | s_valid / s_ready | in_item_t  (limb loads, start)
//  m_       | out       | m_valid / m_ready | out_item_t (result limbs)
//  cfg_     | in        | cfg_we            | cfg_addr, cfg_wdata
//
// Load transactions are accepted back to back while idle. A start runs the
// permutation on the shared field unit: an add is reduced by repeated subtraction
// of r, and a multiply doubles and conditionally adds once per multiplier bit over
// 255 bits. s_ready is low for the whole run and while the 4*width result limbs
// are emitted; a stalled m_ready simply holds the current limb. Reset is synchronous
// and clears control only; the limb stores are undefined until written.
// ---------------------------------------------------------------------------
module griffin_permutation_unit import grif_pkg::*; #(
    parameter int MAX_ROUNDS = 16,
    parameter int MAX_WIDTH  = 4
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data,
    input  logic      cfg_we,
    input  logic      cfg_addr,
    input  logic [4:0] cfg_wdata
);

    localparam int KEY_ELEMS  = MAX_ROUNDS * MAX_WIDTH;
    localparam int COEF_ELEMS = 2 * (MAX_WIDTH - 2);
    localparam int KEY_AW     = $clog2(KEY_ELEMS);
    localparam int KB_W       = $clog2(KEY_ELEMS + 1);
    localparam int PERM_AW    = $clog2(MAX_WIDTH);
    localparam int COEF_AW    = (COEF_ELEMS > 1) ? $clog2(COEF_ELEMS) : 1;
    localparam int RC_W       = $clog2(MAX_ROUNDS + 1);

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_ROUNDS = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD,
        ST_EXE,
        ST_WAIT,
        ST_ORD,
        ST_OLD,
        ST_EMIT
    } state_t;

    typedef enum logic [3:0] {
        PH_LOAD_S,
        PH_LOAD_C,
        PH_LCOPY,
        PH_LSUM,
        PH_LOUT,
        PH_CPRE,
        PH_CTAIL,
        PH_CFIN,
        PH_POW5,
        PH_MIX,
        PH_KEY
    } phase_t;

    typedef enum logic [1:0] {
        EXT_NONE,
        EXT_PERM,
        EXT_COEF,
        EXT_KEY
    } ext_t;

    state_t           state_reg;
    phase_t           ph_reg;
    logic [5:0]       i_reg;
    logic [2:0]       j_reg;
    logic [3:0]       kk_reg;
    logic [RC_W-1:0]  r_reg;
    logic [KB_W-1:0]  key_base_reg;
    logic             in_round_reg;
    logic [1:0]       oi_reg;
    logic [1:0]       ol_reg;
    logic [FE_W-1:0]  out_buf_reg;
    logic             m_valid_reg;
    out_item_t        m_data_reg;
    logic [2:0]       state_width_reg;
    logic [4:0]       round_count_reg;

    // limb stores
    logic [63:0] perm_mem [LIMBS][MAX_WIDTH];
    logic [63:0] coef_mem [LIMBS][COEF_ELEMS];
    logic [63:0] key_mem  [LIMBS][KEY_ELEMS];
    logic [63:0] perm_q [LIMBS];
    logic [63:0] coef_q [LIMBS];
    logic [63:0] key_q  [LIMBS];

    // element file
    logic [FE_W-1:0] fe_mem [FE_DEPTH];
    logic [FE_W-1:0] fe_a_q;
    logic [FE_W-1:0] fe_b_q;

    // current micro-op
    fop_t             op_fop;
    logic [FE_AW-1:0] op_a;
    logic [FE_AW-1:0] op_b;
    logic             op_bzero;
    ext_t             op_ext;
    logic [FE_AW-1:0] op_dst;

    logic             w4;
    logic [1:0]       w_last;
    logic [RC_W-1:0]  nr;
    logic [RC_W-1:0]  r_inc;
    logic [KB_W-1:0]  key_sum;
    logic [FE_AW-1:0] s_i;
    logic [1:0]       i_next;
    logic [FE_AW-1:0] rd_a_addr;
    logic             in_acc;
    logic             in_wr_state;
    logic [FE_W-1:0]  ext_word;
    logic [FE_W-1:0]  alu_a;
    logic [FE_W-1:0]  alu_b;
    alu_req_t         alu_req;
    logic             alu_done;
    logic [FE_W-1:0]  alu_y;
    logic             fe_we;

    assign w4      = (state_width_reg >= 3'd4) && (MAX_WIDTH == 4);
    assign w_last  = w4 ? 2'd3 : 2'd2;
    assign nr      = (32'(round_count_reg) > MAX_ROUNDS) ? RC_W'(MAX_ROUNDS)
                                                         : RC_W'(round_count_reg);
    assign r_inc   = r_reg + RC_W'(1);
    assign key_sum = key_base_reg + KB_W'(i_reg[1:0]);
    assign s_i     = FA_S + FE_AW'(i_reg[1:0]);
    // neighbour element index wraps within the state
    assign i_next  = i_reg[1:0] + 2'd1;

    assign s_ready     = (state_reg == ST_IDLE);
    assign in_acc      = s_valid && s_ready;
    assign in_wr_state = in_acc && (s_data.func == FN_STATE);

    // micro-op decode
    always_comb begin
        op_fop   = FOP_ADD;
        op_a     = s_i;
        op_b     = s_i;
        op_bzero = 1'b1;
        op_ext   = EXT_NONE;
        op_dst   = s_i;
        case (ph_reg)
            PH_LOAD_S: begin
                op_ext = EXT_PERM;
            end
            PH_LOAD_C: begin
                op_ext = EXT_COEF;
                op_dst = FA_C + FE_AW'(i_reg[1:0]);
            end
            PH_LCOPY: begin
                op_dst = FA_X + FE_AW'(i_reg[1:0]);
            end
            PH_LSUM: begin
                op_a     = (i_reg == 6'd1) ? FA_X : FA_SUM;
                op_b     = FA_X + FE_AW'(i_reg[1:0]);
                op_bzero = 1'b0;
                op_dst   = FA_SUM;
            end
            PH_LOUT: begin
                op_bzero = 1'b0;
                case (j_reg)
                    3'd0: begin
                        op_a = FA_X + FE_AW'(i_reg[1:0]);
                        op_b = FA_SUM;
                    end
                    3'd1: op_b = FA_X + FE_AW'(i_reg[1:0]);
                    default: op_b = FA_X + FE_AW'(i_next);
                endcase
            end
            PH_CPRE: begin
                op_fop   = FOP_MUL;
                op_a     = chain_addr(CHAIN_PRE_A[i_reg[4:0]]);
                op_b     = chain_addr(CHAIN_PRE_B[i_reg[4:0]]);
                op_bzero = 1'b0;
                op_dst   = FE_AW'(i_reg);
            end
            PH_CTAIL: begin
                op_fop   = FOP_MUL;
                op_a     = FA_ACC;
                op_b     = (kk_reg < CHAIN_TAIL_SQ[i_reg])
                           ? FA_ACC : chain_addr(CHAIN_TAIL_M[i_reg]);
                op_bzero = 1'b0;
                op_dst   = FA_ACC;
            end
            PH_CFIN: begin
                op_a   = FA_ACC;
                op_dst = FA_S;
            end
            PH_POW5: begin
                op_fop   = FOP_MUL;
                op_bzero = 1'b0;
                case (j_reg)
                    3'd0: begin
                        op_a   = FA_S + 6'd1;
                        op_b   = FA_S + 6'd1;
                        op_dst = FA_T;
                    end
                    3'd1: begin
                        op_a   = FA_T;
                        op_b   = FA_T;
                        op_dst = FA_T;
                    end
                    default: begin
                        op_a   = FA_S + 6'd1;
                        op_b   = FA_T;
                        op_dst = FA_S + 6'd1;
                    end
                endcase
            end
            PH_MIX: begin
                op_bzero = 1'b0;
                case (j_reg)
                    3'd0: begin
                        op_a   = (i_reg == 6'd0) ? (FA_S + 6'd1) : FA_ACC2;
                        op_b   = FA_S;
                        op_dst = FA_ACC2;
                    end
                    3'd1: begin
                        // no previous element on the first branch
                        op_a     = FA_ACC2;
                        op_b     = FA_PREV;
                        op_bzero = (i_reg == 6'd0);
                        op_dst   = FA_ACC2;
                    end
                    3'd2: begin
                        op_fop = FOP_MUL;
                        op_a   = FA_ACC2;
                        op_b   = FA_ACC2;
                        op_dst = FA_RES;
                    end
                    3'd3: begin
                        op_fop = FOP_MUL;
                        op_a   = FA_ACC2;
                        op_b   = FA_C + FE_AW'({i_reg[0], 1'b0});
                        op_dst = FA_T;
                    end
                    3'd4: begin
                        op_a   = FA_RES;
                        op_b   = FA_T;
                        op_dst = FA_RES;
                    end
                    3'd5: begin
                        op_a   = FA_RES;
                        op_b   = FA_C + FE_AW'({i_reg[0], 1'b1});
                        op_dst = FA_RES;
                    end
                    3'd6: begin
                        op_a     = FA_S + FE_AW'(i_reg[1:0] + 2'd2);
                        op_bzero = 1'b1;
                        op_dst   = FA_PREV;
                    end
                    default: begin
                        op_fop = FOP_MUL;
                        op_a   = FA_RES;
                        op_b   = FA_PREV;
                        op_dst = FA_S + FE_AW'(i_reg[1:0] + 2'd2);
                    end
                endcase
            end
            PH_KEY: begin
                if (j_reg == 3'd0) begin
                    op_ext = EXT_KEY;
                    op_dst = FA_K;
                end else begin
                    op_b     = FA_K;
                    op_bzero = 1'b0;
                end
            end
            default: ;
        endcase
    end

    assign rd_a_addr = (state_reg == ST_ORD || state_reg == ST_OLD)
                       ? (FA_S + FE_AW'(oi_reg)) : op_a;

    always_comb begin
        case (op_ext)
            EXT_PERM: ext_word = {perm_q[3], perm_q[2], perm_q[1], perm_q[0]};
            EXT_COEF: ext_word = {coef_q[3], coef_q[2], coef_q[1], coef_q[0]};
            EXT_KEY:  ext_word = {key_q[3], key_q[2], key_q[1], key_q[0]};
            default:  ext_word = fe_a_q;
        endcase
    end

    assign alu_a         = ext_word;
    assign alu_b         = op_bzero ? '0 : fe_b_q;
    assign alu_req.start = (state_reg == ST_EXE);
    assign alu_req.op    = op_fop;
    assign fe_we         = (state_reg == ST_WAIT) && alu_done;

    grif_falu u_falu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (alu_req),
        .a       (alu_a),
        .b       (alu_b),
        .done    (alu_done),
        .y       (alu_y)
    );

    // element file
    always_ff @(posedge aclk) begin
        if (fe_we) begin
            fe_mem[op_dst] <= alu_y;
        end
        fe_a_q <= fe_mem[rd_a_addr];
        fe_b_q <= fe_mem[op_b];
    end

    // limb stores
    always_ff @(posedge aclk) begin
        if (in_wr_state && (32'(s_data.element) < MAX_WIDTH)) begin
            perm_mem[s_data.limb][PERM_AW'(s_data.element)] <= s_data.word;
        end else if (state_reg == ST_OLD) begin
            for (int l = 0; l < LIMBS; l++) begin
                perm_mem[l][PERM_AW'(oi_reg)] <= fe_a_q[l*64 +: 64];
            end
        end
        if (in_acc && s_data.func == FN_COEF && 32'(s_data.element) < COEF_ELEMS) begin
            coef_mem[s_data.limb][COEF_AW'(s_data.element)] <= s_data.word;
        end
        if (in_acc && s_data.func == FN_KEY && 32'(s_data.element) < KEY_ELEMS) begin
            key_mem[s_data.limb][KEY_AW'(s_data.element)] <= s_data.word;
        end
        for (int l = 0; l < LIMBS; l++) begin
            perm_q[l] <= perm_mem[l][PERM_AW'(i_reg)];
            coef_q[l] <= coef_mem[l][COEF_AW'(i_reg)];
            key_q[l]  <= key_mem[l][key_sum[KEY_AW-1:0]];
        end
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            ph_reg          <= PH_LOAD_S;
            i_reg           <= '0;
            j_reg           <= '0;
            kk_reg          <= '0;
            r_reg           <= '0;
            key_base_reg    <= '0;
            in_round_reg    <= 1'b0;
            oi_reg          <= '0;
            ol_reg          <= '0;
            m_valid_reg     <= 1'b0;
            state_width_reg <= 3'd3;
            round_count_reg <= 5'd12;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_WIDTH:  state_width_reg <= cfg_wdata[2:0];
                    CFG_ROUNDS: round_count_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            case (state_reg)
                ST_IDLE: begin
                    if (in_wr_state && s_data.start_req) begin
                        ph_reg       <= PH_LOAD_S;
                        i_reg        <= '0;
                        j_reg        <= '0;
                        kk_reg       <= '0;
                        r_reg        <= '0;
                        key_base_reg <= '0;
                        in_round_reg <= 1'b0;
                        state_reg    <= ST_RD;
                    end
                end
                ST_RD:   state_reg <= ST_EXE;
                ST_EXE:  state_reg <= ST_WAIT;
                ST_WAIT: begin
                    if (alu_done) begin
                        state_reg <= ST_RD;
                        case (ph_reg)
                            PH_LOAD_S: begin
                                if (i_reg == {4'd0, w_last}) begin
                                    ph_reg <= PH_LOAD_C;
                                    i_reg  <= '0;
                                end else begin
                                    i_reg <= i_reg + 6'd1;
                                end
                            end
                            PH_LOAD_C: begin
                                if (i_reg == 6'(COEF_ELEMS - 1)) begin
                                    ph_reg <= PH_LCOPY;
                                    i_reg  <= '0;
                                end else begin
                                    i_reg <= i_reg + 6'd1;
                                end
                            end
                            PH_LCOPY: begin
                                if (i_reg == {4'd0, w_last}) begin
                                    ph_reg <= PH_LSUM;
                                    i_reg  <= 6'd1;
                                end else begin
                                    i_reg <= i_reg + 6'd1;
                                end
                            end
                            PH_LSUM: begin
                                if (i_reg == {4'd0, w_last}) begin
                                    ph_reg <= PH_LOUT;
                                    i_reg  <= '0;
                                    j_reg  <= '0;
                                end else begin
                                    i_reg <= i_reg + 6'd1;
                                end
                            end
                            PH_LOUT: begin
                                if (j_reg == (w4 ? 3'd2 : 3'd0)) begin
                                    j_reg <= '0;
                                    if (i_reg == {4'd0, w_last}) begin
                                        i_reg <= '0;
                                        if (in_round_reg) begin
                                            ph_reg <= PH_KEY;
                                        end else if (nr == '0) begin
                                            oi_reg    <= '0;
                                            state_reg <= ST_ORD;
                                        end else begin
                                            ph_reg <= PH_CPRE;
                                        end
                                    end else begin
                                        i_reg <= i_reg + 6'd1;
                                    end
                                end else begin
                                    j_reg <= j_reg + 3'd1;
                                end
                            end
                            PH_CPRE: begin
                                if (i_reg == 6'(PRE_LEN - 1)) begin
                                    ph_reg <= PH_CTAIL;
                                    i_reg  <= '0;
                                    kk_reg <= '0;
                                end else begin
                                    i_reg <= i_reg + 6'd1;
                                end
                            end
                            PH_CTAIL: begin
                                if (kk_reg < CHAIN_TAIL_SQ[i_reg]) begin
                                    kk_reg <= kk_reg + 4'd1;
                                end else begin
                                    kk_reg <= '0;
                                    if (i_reg == 6'(TAIL_LEN - 1)) begin
                                        ph_reg <= PH_CFIN;
                                        i_reg  <= '0;
                                    end else begin
                                        i_reg <= i_reg + 6'd1;
                                    end
                                end
                            end
                            PH_CFIN: begin
                                ph_reg <= PH_POW5;
                                j_reg  <= '0;
                            end
                            PH_POW5: begin
                                if (j_reg == 3'd2) begin
                                    ph_reg <= PH_MIX;
                                    i_reg  <= '0;
                                    j_reg  <= '0;
                                end else begin
                                    j_reg <= j_reg + 3'd1;
                                end
                            end
                            PH_MIX: begin
                                if (j_reg == 3'd7) begin
                                    j_reg <= '0;
                                    if (i_reg == {4'd0, w_last - 2'd2}) begin
                                        ph_reg       <= PH_LCOPY;
                                        i_reg        <= '0;
                                        in_round_reg <= 1'b1;
                                    end else begin
                                        i_reg <= i_reg + 6'd1;
                                    end
                                end else begin
                                    j_reg <= j_reg + 3'd1;
                                end
                            end
                            PH_KEY: begin
                                if (j_reg == 3'd0) begin
                                    j_reg <= 3'd1;
                                end else begin
                                    j_reg <= '0;
                                    if (i_reg == {4'd0, w_last}) begin
                                        i_reg        <= '0;
                                        r_reg        <= r_inc;
                                        key_base_reg <= key_base_reg
                                                        + KB_W'(w4 ? 3'd4 : 3'd3);
                                        if (r_inc == nr) begin
                                            oi_reg    <= '0;
                                            state_reg <= ST_ORD;
                                        end else begin
                                            ph_reg <= PH_CPRE;
                                        end
                                    end else begin
                                        i_reg <= i_reg + 6'd1;
                                    end
                                end
                            end
                            default: state_reg <= ST_IDLE;
                        endcase
                    end
                end
                ST_ORD:  state_reg <= ST_OLD;
                ST_OLD: begin
                    out_buf_reg            <= fe_a_q;
                    ol_reg                 <= '0;
                    m_valid_reg            <= 1'b1;
                    m_data_reg.out_element <= oi_reg;
                    m_data_reg.out_limb    <= 2'd0;
                    m_data_reg.out_word    <= fe_a_q[63:0];
                    m_data_reg.last        <= 1'b0;
                    state_reg              <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (m_ready) begin
                        if (ol_reg == 2'd3) begin
                            m_valid_reg <= 1'b0;
                            if (oi_reg == w_last) begin
                                state_reg <= ST_IDLE;
                            end else begin
                                oi_reg    <= oi_reg + 2'd1;
                                state_reg <= ST_ORD;
                            end
                        end else begin
                            ol_reg                 <= ol_reg + 2'd1;
                            m_data_reg.out_limb    <= ol_reg + 2'd1;
                            m_data_reg.out_word    <= out_buf_reg[(ol_reg + 2'd1)*64 +: 64];
                            m_data_reg.last        <= (oi_reg == w_last)
                                                      && (ol_reg == 2'd2);
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // result limbs only appear while emitting, never alongside input acceptance
    a_emit_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (state_reg == ST_EMIT) && !s_ready)
        else $error("result valid outside emission");

    // last flag marks the final limb of the final element
    a_last_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.last) |-> (m_data.out_limb == 2'd3)
                                     && (m_data.out_element == w_last))
        else $error("last flag on wrong limb");

    // element file is written only by a completing field operation
    a_fe_write: assert property (@(posedge aclk) disable iff (!aresetn)
        alu_done |-> (state_reg == ST_WAIT) && ($past(state_reg) == ST_WAIT
                                                || $past(state_reg) == ST_EXE))
        else $error("field unit finished outside an operation");

endmodule
